// ===== sv/gnt_pkg.sv =====
// ----------------------------------------------------------------------------
// gnt_pkg: shared types and constants for the gradient noise block
// Field structs, function codes and fixed-point constants.
// ----------------------------------------------------------------------------
package gnt_pkg;

    localparam int TABLE_SIZE      = 256;
    localparam int TBL_W           = $clog2(TABLE_SIZE);
    localparam int MAX_OCTAVES     = 8;
    localparam int COORD_FRAC_BITS = 16;
    localparam int GRAD_FRAC_BITS  = 14;
    localparam int OCT_W           = 4;

    localparam logic [2:0] FUNC_LOAD_GRAD = 3'd0;
    localparam logic [2:0] FUNC_LOAD_PX   = 3'd1;
    localparam logic [2:0] FUNC_LOAD_PY   = 3'd2;
    localparam logic [2:0] FUNC_LOAD_PZ   = 3'd3;
    localparam logic [2:0] FUNC_NOISE     = 3'd4;
    localparam logic [2:0] FUNC_TURB      = 3'd5;

    localparam logic signed [18:0] OUT_MAX = 19'sd262143;
    localparam logic signed [18:0] OUT_MIN = -19'sd262144;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         table_index;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
        logic [7:0]         perm_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [3:0]         octaves;
    } t_in;

    typedef struct packed {
        logic signed [18:0] value;
        logic               is_query;
    } t_out;

    typedef struct packed {
        logic               go;
        logic signed [33:0] a;
        logic signed [33:0] b;
    } t_mul_req;

endpackage

// ===== sv/gradient_noise_turbulence.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_turbulence: 3D gradient noise with turbulence
// Table loads, corner hashing, dot products and smoothstep blending on one
// shared multiplier under a step sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  input   | i_valid, o_stall         | i_data  (t_in)
//  output  | o_valid, i_stall         | o_data  (t_out)
//
// A load passes through the done step before its result is valid. A query
// runs, per octave, axis setup for all three axes, the eight corners and the
// octave step, then the done step; all steps share the single multiplier.
// Reset clears the sequencer and output valid; the tables are not cleared.
// The input stalls while an item is in work or its result is not taken, so the
// next input transfer comes at the earliest in the cycle after the result transfer.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  gnt_pkg::t_in     i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output gnt_pkg::t_out    o_data
);
    localparam int F  = gnt_pkg::COORD_FRAC_BITS;
    localparam int G  = gnt_pkg::GRAD_FRAC_BITS;
    localparam int TW = gnt_pkg::TBL_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AXIS = 3'd1;
    localparam logic [2:0] S_CORN = 3'd2;
    localparam logic [2:0] S_OCT  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [47:0]   r_grad [gnt_pkg::TABLE_SIZE];
    logic [7:0]    r_px   [gnt_pkg::TABLE_SIZE];
    logic [7:0]    r_py   [gnt_pkg::TABLE_SIZE];
    logic [7:0]    r_pz   [gnt_pkg::TABLE_SIZE];

    logic [2:0]    r_state;
    logic [3:0]    r_step;
    logic [1:0]    r_ax;
    logic [2:0]    r_corner;
    logic [3:0]    r_oct;
    logic [3:0]    r_noct;
    logic          r_turb;
    gnt_pkg::t_in  r_in;
    logic [F-1:0]  r_f   [3];
    logic [TW-1:0] r_c   [3];
    logic [F:0]    r_s   [3];
    logic [7:0]    r_hx, r_hy, r_hz;
    logic [47:0]   r_g;
    logic signed [63:0] r_dot;
    logic [F:0]    r_wxy;
    logic [F:0]    r_w;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_tacc;
    logic          r_oval;
    gnt_pkg::t_out r_out;

    gnt_pkg::t_mul_req mreq;
    logic signed [67:0] mp;

    gnt_mul u_mul (.i_clk(i_clk), .i_req(mreq), .o_p(mp));

    logic [63:0] ucoord;
    logic        di, dj, dk;
    logic signed [F+1:0] ox, oy, oz;
    logic [F:0]  wx, wy, wz;

    always_comb begin
        unique case (r_ax)
            2'd0:    ucoord = 64'(signed'(r_in.point_x)) << r_oct;
            2'd1:    ucoord = 64'(signed'(r_in.point_y)) << r_oct;
            default: ucoord = 64'(signed'(r_in.point_z)) << r_oct;
        endcase
        di = r_corner[2];
        dj = r_corner[1];
        dk = r_corner[0];
        ox = $signed({2'b00, r_f[0]}) - (di ? $signed((F+2)'(1) << F) : '0);
        oy = $signed({2'b00, r_f[1]}) - (dj ? $signed((F+2)'(1) << F) : '0);
        oz = $signed({2'b00, r_f[2]}) - (dk ? $signed((F+2)'(1) << F) : '0);
        wx = di ? r_s[0] : ((F+1)'(1) << F) - r_s[0];
        wy = dj ? r_s[1] : ((F+1)'(1) << F) - r_s[1];
        wz = dk ? r_s[2] : ((F+1)'(1) << F) - r_s[2];
    end

    // Step plan. Axis: per axis step 0 (f*f), 1 (t*(3-2f)), 2 store.
    // Corner: 0 read perms, 1 read grad, 2..4 dot terms, 5 and 7 weights,
    // 9 weighted term, 10 accumulate.
    always_comb begin
        mreq.go = 1'b0;
        mreq.a  = '0;
        mreq.b  = '0;
        if (r_state == S_AXIS) begin
            unique case (r_step)
                4'd0: begin
                    mreq.go = 1'b1;
                    mreq.a  = 34'(ucoord[F-1:0]);
                    mreq.b  = 34'(ucoord[F-1:0]);
                end
                4'd1: begin
                    mreq.go = 1'b1;
                    mreq.a  = 34'(mp[2*F-1:F]);
                    mreq.b  = 34'(3 * (1 << F)) - 34'({r_f[r_ax], 1'b0});
                end
                default: ;
            endcase
        end else if (r_state == S_CORN) begin
            unique case (r_step)
                4'd2: begin mreq.go = 1'b1; mreq.a = 34'(ox);
                    mreq.b = 34'($signed(r_g[47:32])); end
                4'd3: begin mreq.go = 1'b1; mreq.a = 34'(oy);
                    mreq.b = 34'($signed(r_g[31:16])); end
                4'd4: begin mreq.go = 1'b1; mreq.a = 34'(oz);
                    mreq.b = 34'($signed(r_g[15:0])); end
                4'd5: begin mreq.go = 1'b1; mreq.a = 34'(wx); mreq.b = 34'(wy); end
                4'd7: begin mreq.go = 1'b1; mreq.a = 34'(r_wxy); mreq.b = 34'(wz); end
                4'd9: begin mreq.go = 1'b1; mreq.a = 34'(r_dot >>> G);
                    mreq.b = 34'(r_w); end
                default: ;
            endcase
        end
    end

    logic accept;
    logic signed [63:0] nz, tsum, fin;
    logic signed [18:0] sat;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_oval;

    always_comb begin
        nz   = r_acc >>> F;
        tsum = r_tacc + (nz >>> r_oct);
        fin  = r_turb ? ((r_tacc < 0) ? -r_tacc : r_tacc) : r_acc >>> F;
        if (fin > 64'(gnt_pkg::OUT_MAX))      sat = gnt_pkg::OUT_MAX;
        else if (fin < 64'(gnt_pkg::OUT_MIN)) sat = gnt_pkg::OUT_MIN;
        else                                   sat = fin[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
            unique case (i_data.func)
                gnt_pkg::FUNC_LOAD_GRAD: r_grad[i_data.table_index[TW-1:0]] <=
                    {i_data.grad_x, i_data.grad_y, i_data.grad_z};
                gnt_pkg::FUNC_LOAD_PX: r_px[i_data.table_index[TW-1:0]] <= i_data.perm_value;
                gnt_pkg::FUNC_LOAD_PY: r_py[i_data.table_index[TW-1:0]] <= i_data.perm_value;
                gnt_pkg::FUNC_LOAD_PZ: r_pz[i_data.table_index[TW-1:0]] <= i_data.perm_value;
                default: ;
            endcase
        end
        if (r_state == S_CORN && r_step == 4'd0) begin
            r_hx <= r_px[r_c[0] + TW'(di)];
            r_hy <= r_py[r_c[1] + TW'(dj)];
            r_hz <= r_pz[r_c[2] + TW'(dk)];
        end
        if (r_state == S_CORN && r_step == 4'd1) begin
            r_g <= r_grad[(r_hx ^ r_hy ^ r_hz) & 8'(gnt_pkg::TABLE_SIZE - 1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_step  <= '0;
        end else begin
            if (o_valid && !i_stall) r_oval <= 1'b0;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_oct  <= '0;
                    r_tacc <= '0;
                    r_step <= '0;
                    r_ax   <= '0;
                    r_turb <= i_data.func == gnt_pkg::FUNC_TURB;
                    r_noct <= (i_data.octaves > 4'(gnt_pkg::MAX_OCTAVES)) ?
                              4'(gnt_pkg::MAX_OCTAVES) : i_data.octaves;
                    if (i_data.func == gnt_pkg::FUNC_NOISE ||
                        (i_data.func == gnt_pkg::FUNC_TURB && i_data.octaves != 4'd0))
                        r_state <= S_AXIS;
                    else begin
                        r_state <= S_DONE;
                        r_acc   <= '0;
                    end
                end
                S_AXIS: begin
                    if (r_step == 4'd0) begin
                        r_f[r_ax] <= ucoord[F-1:0];
                        r_c[r_ax] <= ucoord[F+TW-1:F];
                    end else if (r_step == 4'd2) begin
                        r_s[r_ax] <= mp[2*F:F];
                    end
                    if (r_step == 4'd2) begin
                        r_step <= '0;
                        if (r_ax == 2'd2) begin
                            r_ax     <= '0;
                            r_corner <= '0;
                            r_acc    <= '0;
                            r_state  <= S_CORN;
                        end else r_ax <= r_ax + 2'd1;
                    end else r_step <= r_step + 4'd1;
                end
                S_CORN: begin
                    if (r_step == 4'd3) r_dot <= 64'(mp);
                    if (r_step == 4'd4 || r_step == 4'd5) r_dot <= r_dot + 64'(mp);
                    if (r_step == 4'd6) r_wxy <= mp[2*F:F];
                    if (r_step == 4'd8) r_w <= mp[2*F:F];
                    if (r_step == 4'd10) begin
                        r_acc  <= r_acc + 64'(mp);
                        r_step <= '0;
                        if (r_corner == 3'd7) r_state <= S_OCT;
                        r_corner <= r_corner + 3'd1;
                    end else r_step <= r_step + 4'd1;
                end
                S_OCT: begin
                    r_tacc <= tsum;
                    if (!r_turb || r_oct + 4'd1 == r_noct) r_state <= S_DONE;
                    else begin
                        r_oct   <= r_oct + 4'd1;
                        r_step  <= '0;
                        r_ax    <= '0;
                        r_state <= S_AXIS;
                    end
                end
                S_DONE: begin
                    r_oval <= 1'b1;
                    r_out.is_query <= r_in.func == gnt_pkg::FUNC_NOISE ||
                                      r_in.func == gnt_pkg::FUNC_TURB;
                    r_out.value <= (r_in.func == gnt_pkg::FUNC_NOISE ||
                                    r_in.func == gnt_pkg::FUNC_TURB) ? sat : '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_oval;
    assign o_data  = r_out;

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepted while busy");
    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.is_query) |-> (o_data.value == '0))
        else $error("load ack with nonzero value");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("result lost");
endmodule

// ===== sv/gnt_mul.sv =====
// ----------------------------------------------------------------------------
// gnt_mul: shared registered multiplier
// One signed 34x34 product per cycle, result registered.
// ----------------------------------------------------------------------------
module gnt_mul (
    input  logic                i_clk,
    input  gnt_pkg::t_mul_req   i_req,
    output logic signed [67:0]  o_p
);
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            o_p <= i_req.a * i_req.b;
        end
    end
endmodule
